FILE: design/b2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared types and constants for the binary to decimal digit split unit.
// ----------------------------------------------------------------------------
package b2d_pkg;

  localparam int VALUE_W   = 31;
  localparam int DIGIT_W   = 4;
  localparam int POS_W     = 4;
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic advance;
  } cell_ctrl_t;

endpackage

FILE: design/b2d_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_cell
// One BCD digit cell: add-3 and shift during conversion, digit shift upward
// while digits are read out.
// ----------------------------------------------------------------------------
module b2d_cell
  import b2d_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               carry_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] adj;

  assign adj       = (digit >= DIGIT_W'(5)) ? digit + DIGIT_W'(3) : digit;
  assign carry_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.advance) begin
      digit <= digit_in;
    end
  end

endmodule

FILE: design/binary_to_decimal_digit_split_unit.sv
`timescale 1ns / 1ps
// Conversion: 31 shift-and-add-3 passes through the digit cell chain, then a skip
//   step for each suppressed leading zero digit and a readout for each shown digit.
// A new value is taken only once the last digit of the previous one is loaded for
//   output; result_stall holds the readout.
// Reset: synchronous, returns the controller to idle and drops result_valid.
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_split_unit
// Double dabble over a chain of BCD digit cells, then digits read out most
// significant first with leading zeros skipped unless the value overflows the chain.
// ----------------------------------------------------------------------------
module binary_to_decimal_digit_split_unit
  import b2d_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [VALUE_W-1:0] value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [DIGIT_W-1:0] digit,
  output logic [POS_W-1:0]   position,
  output logic               last
);

  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  state_t               state, state_next;
  cell_ctrl_t           ctrl;
  logic [VALUE_W-1:0]   shreg;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [PW-1:0]        pos;
  logic                 load_out;
  logic                 ovf;

  logic [MAX_DIGITS-1:0] carry;
  logic [DIGIT_W-1:0]    cell_digit [MAX_DIGITS];
  logic [DIGIT_W-1:0]    top_digit;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        b2d_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .bit_in    (shreg[VALUE_W-1]),
          .digit_in  ('0),
          .carry_out (carry[gi]),
          .digit     (cell_digit[gi])
        );
      end else begin : g_rest
        b2d_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .bit_in    (carry[gi-1]),
          .digit_in  (cell_digit[gi-1]),
          .carry_out (carry[gi]),
          .digit     (cell_digit[gi])
        );
      end
    end
  endgenerate

  assign top_digit = cell_digit[MAX_DIGITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    load_out   = 1'b0;
    item_stall = rst || (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          ctrl.clear = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctrl.dabble = 1'b1;
        if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // value wider than the chain: keep every held digit
        if (!ovf && top_digit == '0 && pos != '0) begin
          ctrl.advance = 1'b1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          load_out     = 1'b1;
          ctrl.advance = 1'b1;
          if (pos == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      shreg   <= value;
      bit_cnt <= '0;
      pos     <= PW'(MAX_DIGITS - 1);
      ovf     <= 1'b0;
    end else begin
      if (ctrl.dabble) begin
        shreg   <= {shreg[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
        if (carry[MAX_DIGITS-1]) begin
          ovf <= 1'b1;
        end
      end
      if (ctrl.advance) begin
        pos <= pos - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digit    <= top_digit;
      position <= POS_W'(pos);
      last     <= (pos == '0);
    end
  end

endmodule

FILE: design/b2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_checker
// Port-level checks on the digit split unit, bound to the top level.
// ----------------------------------------------------------------------------
module b2d_checker
  import b2d_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic [VALUE_W-1:0] value,
  input logic               result_valid,
  input logic               result_stall,
  input logic [DIGIT_W-1:0] digit,
  input logic [POS_W-1:0]   position,
  input logic               last
);

  // held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(digit)
      && $stable(position) && $stable(last))
    else $error("result beat changed while stalled");

  a_digit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> digit <= DIGIT_W'(9))
    else $error("digit out of decimal range");

  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> position == '0)
    else $error("last mark away from units position");

  // no new value while a run is still being read out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !last |-> item_stall)
    else $error("value taken in the middle of a digit run");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("unit idle right after taking a value");

endmodule

bind binary_to_decimal_digit_split_unit b2d_checker u_b2d_checker (.*);
